@@ design/msk_pkg.sv @@
`default_nettype none

package msk_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned FILL_W      = 7;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 112;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_POPMAX = 2'd3
  } msk_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } msk_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE_INIT,
    S_PRE_SCAN,
    S_TAKE,
    S_SHIFT_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_POST_INIT,
    S_POST_SCAN,
    S_DONE
  } msk_state_e;

  typedef struct packed {
    logic load;
    logic push;
    logic scan_init;
    logic scan_step;
    logic take_removed;
    logic shift_rd;
    logic shift_wr;
    logic drop;
    logic emit;
  } msk_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic scan_done;
    logic shift_more;
    logic out_free;
  } msk_stat_t;

endpackage

`default_nettype wire

@@ design/msk_ctrl.sv @@
`default_nettype none

module msk_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire msk_pkg::msk_op_e  opcode_i,
  input  wire msk_pkg::msk_stat_t stat_i,
  output msk_pkg::msk_cmd_t      cmd_o
);
  import msk_pkg::*;

  msk_state_e state_q, state_d;
  logic       accept;
  logic       is_pop;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign is_pop = (opcode_i == OP_POP) || (opcode_i == OP_POPMAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_pop && !stat_i.count_zero) state_d = S_PRE_INIT;
          else                              state_d = S_POST_INIT;
        end
      end
      S_PRE_INIT:  state_d = S_PRE_SCAN;
      S_PRE_SCAN: begin
        if (stat_i.scan_done) state_d = S_TAKE;
      end
      S_TAKE:      state_d = S_SHIFT_CHK;
      S_SHIFT_CHK: begin
        if (stat_i.shift_more) state_d = S_SHIFT_RD;
        else                   state_d = S_POST_INIT;
      end
      S_SHIFT_RD:  state_d = S_SHIFT_WR;
      S_SHIFT_WR:  state_d = S_SHIFT_CHK;
      S_POST_INIT: state_d = S_POST_SCAN;
      S_POST_SCAN: begin
        if (stat_i.scan_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = accept;
        cmd_o.push = accept && (opcode_i == OP_PUSH) && !stat_i.count_full;
      end
      S_PRE_INIT, S_POST_INIT: cmd_o.scan_init = 1'b1;
      S_PRE_SCAN, S_POST_SCAN: cmd_o.scan_step = 1'b1;
      S_TAKE:      cmd_o.take_removed = 1'b1;
      S_SHIFT_CHK: cmd_o.drop = !stat_i.shift_more;
      S_SHIFT_RD:  cmd_o.shift_rd = 1'b1;
      S_SHIFT_WR:  cmd_o.shift_wr = 1'b1;
      S_DONE:      cmd_o.emit = stat_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/msk_datapath.sv @@
`default_nettype none

module msk_datapath #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire msk_pkg::msk_cmd_t                 cmd_i,
  output msk_pkg::msk_stat_t                     stat_o,
  input  wire msk_pkg::msk_op_e                  opcode_i,
  input  wire logic [msk_pkg::WORD_W-1:0]        push_value_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [msk_pkg::OUT_TDATA_W-1:0]        out_data_o
);
  import msk_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] mem [STACK_DEPTH];

  logic [CW-1:0]     count_q;
  logic [AW-1:0]     addr_q;
  logic              issue_done_q;
  logic              rd_vld_q;
  logic [AW-1:0]     rd_addr_q;
  logic [WORD_W-1:0] rd_data_q;
  logic              first_q;
  logic [WORD_W-1:0] top_q;
  logic [WORD_W-1:0] max_q;
  logic [AW-1:0]     max_idx_q;
  logic [WORD_W-1:0] removed_q;
  msk_op_e           op_q;
  msk_status_e       status_q;
  logic              out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     addr_ext;
  logic [CW-1:0]     addr_nxt;
  logic              count_zero;
  logic              count_full;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [CW+FILL_W-1:0] count_wide;
  logic [FILL_W-1:0] fill;
  logic [WORD_W-1:0] top_out;
  logic [WORD_W-1:0] max_out;

  assign count_m1   = count_q - CW'(1);
  assign addr_ext   = CW'(addr_q);
  assign addr_nxt   = addr_ext + CW'(1);
  assign count_zero = (count_q == '0);
  assign count_full = (count_q == CW'(STACK_DEPTH));

  assign stat_o.count_zero = count_zero;
  assign stat_o.count_full = count_full;
  assign stat_o.scan_done  = issue_done_q && !rd_vld_q;
  assign stat_o.shift_more = (addr_nxt < count_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Memory ports: the scan reads downward from the top, the shift reads one above.
  always_comb begin
    rd_en   = (cmd_i.scan_step && !issue_done_q) || cmd_i.shift_rd;
    rd_addr = cmd_i.shift_rd ? addr_nxt[AW-1:0] : addr_q;
    wr_en   = cmd_i.push || cmd_i.shift_wr;
    wr_addr = cmd_i.push ? count_q[AW-1:0] : addr_q;
    wr_data = cmd_i.push ? push_value_i : rd_data_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      first_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step && !issue_done_q;
      if (cmd_i.push) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.drop) begin
        count_q <= count_m1;
      end
      if (cmd_i.scan_init) begin
        issue_done_q <= count_zero;
        first_q      <= 1'b1;
      end else if (cmd_i.scan_step && !issue_done_q && (addr_q == '0)) begin
        issue_done_q <= 1'b1;
      end
      if (rd_vld_q) begin
        first_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= opcode_i;
      removed_q <= '0;
      if ((opcode_i == OP_PUSH) && count_full) begin
        status_q <= ST_FULL;
      end else if (((opcode_i == OP_POP) || (opcode_i == OP_POPMAX)) && count_zero) begin
        status_q <= ST_EMPTY;
      end else begin
        status_q <= ST_OK;
      end
    end
    if (cmd_i.scan_init) begin
      addr_q <= count_m1[AW-1:0];
    end else if (cmd_i.scan_step && !issue_done_q && (addr_q != '0)) begin
      addr_q <= addr_q - AW'(1);
    end else if (cmd_i.take_removed) begin
      addr_q <= (op_q == OP_POP) ? count_m1[AW-1:0] : max_idx_q;
    end else if (cmd_i.shift_wr) begin
      addr_q <= addr_nxt[AW-1:0];
    end
    // The address travels with the read so it lines up with rd_data_q.
    rd_addr_q <= addr_q;
    if (rd_vld_q) begin
      // Strict compare while walking down keeps the topmost of equal maxima.
      if (first_q) begin
        top_q     <= rd_data_q;
        max_q     <= rd_data_q;
        max_idx_q <= rd_addr_q;
      end else if ($signed(rd_data_q) > $signed(max_q)) begin
        max_q     <= rd_data_q;
        max_idx_q <= rd_addr_q;
      end
    end
    if (cmd_i.take_removed) begin
      removed_q <= (op_q == OP_POP) ? top_q : max_q;
    end
    if (cmd_i.emit) begin
      out_data_q <= {7'b0, status_q, fill, max_out, top_out, removed_q};
    end
  end

  assign count_wide = {{FILL_W{1'b0}}, count_q};
  assign fill       = count_wide[FILL_W-1:0];
  assign top_out    = count_zero ? '0 : top_q;
  assign max_out    = count_zero ? '0 : max_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ design/max_stack_engine.sv @@
`default_nettype none
// A query or push scans the entries once before its result is offered on tvalid; a pop on a
// non-empty stack scans twice, before and after the removal, and a pop-max also shifts down
// each entry above the removed maximum, with a read and a write for each entry.
// Throughput is one item at a time, set by the serial memory scans over the entries.
// The next item is taken while a finished result waits in the output register.
// Reset is asynchronous and active low; it empties the stack, the contents are not cleared.

module max_stack_engine #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // push_value [31:0]
  input  wire logic [msk_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // opcode [1:0]
  input  wire logic [msk_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // removed_value [31:0], top_value [63:32], max_value [95:64], fill_count [102:96],
  // status [104:103], zero fill [111:105]
  output logic [msk_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o
);
  import msk_pkg::*;

  msk_cmd_t  cmd;
  msk_stat_t stat;
  msk_op_e   opcode;

  assign opcode = msk_op_e'(s_axis_tuser_i);

  msk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .opcode_i   (opcode),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  msk_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .opcode_i     (opcode),
    .push_value_i (s_axis_tdata_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_data_o   (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ verif/tb_max_stack_engine.sv @@
`timescale 1ns / 100ps

module tb_max_stack_engine;
  import msk_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned TAIL_CYCLES  = 400;
  localparam int unsigned DIR_ROWS     = 23;

  typedef struct {
    logic [31:0] removed;
    logic [31:0] top;
    logic [31:0] peak;
    logic [6:0]  fill;
    msk_status_e status;
  } stack_result_t;

  // A directed row; when hand is set the result columns are the known answer.
  typedef struct {
    msk_op_e     op;
    logic [31:0] value;
    bit          hand;
    logic [31:0] removed;
    logic [31:0] top;
    logic [31:0] peak;
    logic [6:0]  fill;
    msk_status_e status;
  } dir_row_t;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED,
    PH_PEAKS
  } phase_e;

  logic                   clk;
  logic                   rst_n;
  logic                   s_tvalid;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   s_tready;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [31:0]   stack_mirror [DEPTH];
  int unsigned   mirror_fill;
  stack_result_t owed_results [$];

  int unsigned items_sent;
  int unsigned beats_checked;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned full_refusals;
  int unsigned empty_refusals;
  int unsigned peak_pops;
  int unsigned deepest;
  bit          tx_calm;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_QUERY,  32'h0000_0000, 1'b1, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_POP,    32'h1234_5678, 1'b1, 32'h0, 32'h0, 32'h0, 7'd0, ST_EMPTY},
    '{OP_POPMAX, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0, 32'h0, 7'd0, ST_EMPTY},
    '{OP_PUSH,   32'h7FFF_FFFF, 1'b1, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd1, ST_OK},
    '{OP_PUSH,   32'h8000_0000, 1'b1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 7'd2, ST_OK},
    '{OP_POPMAX, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 7'd1,
      ST_OK},
    '{OP_POP,    32'h0000_0000, 1'b1, 32'h8000_0000, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_PUSH,   32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_PUSH,   32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_PUSH,   32'h0000_0005, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_PUSH,   32'h0000_0005, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_PUSH,   32'hFFFF_FFFD, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_POPMAX, 32'hAAAA_5555, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_QUERY,  32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_POPMAX, 32'h5555_AAAA, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_POP,    32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_PUSH,   32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_PUSH,   32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_POPMAX, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_POP,    32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_POP,    32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_POP,    32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 7'd0, ST_OK},
    '{OP_POP,    32'h0000_0000, 1'b1, 32'h0, 32'h0, 32'h0, 7'd0, ST_EMPTY}
  };

  max_stack_engine dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #10 clk = ~clk;

  // Topmost entry holding the largest signed value; only called with a non-empty stack.
  function automatic int unsigned top_peak_index();
    int unsigned best;
    int unsigned i;
    best = mirror_fill - 1;
    for (i = best; i > 0; i--) begin
      if ($signed(stack_mirror[i-1]) > $signed(stack_mirror[best])) begin
        best = i - 1;
      end
    end
    return best;
  endfunction

  function automatic stack_result_t apply_stack_op(input msk_op_e op, input logic [31:0] value);
    stack_result_t r;
    int unsigned   at;
    int unsigned   i;
    r.removed = '0;
    r.status  = ST_OK;
    case (op)
      OP_PUSH: begin
        if (mirror_fill == DEPTH) begin
          r.status = ST_FULL;
          full_refusals++;
        end else begin
          stack_mirror[mirror_fill] = value;
          mirror_fill++;
        end
      end
      OP_POP, OP_POPMAX: begin
        if (mirror_fill == 0) begin
          r.status = ST_EMPTY;
          empty_refusals++;
        end else if (op == OP_POP) begin
          mirror_fill--;
          r.removed = stack_mirror[mirror_fill];
        end else begin
          at = top_peak_index();
          r.removed = stack_mirror[at];
          for (i = at; i + 1 < mirror_fill; i++) begin
            stack_mirror[i] = stack_mirror[i+1];
          end
          mirror_fill--;
          peak_pops++;
        end
      end
      default: ;
    endcase
    if (mirror_fill == 0) begin
      r.top  = '0;
      r.peak = '0;
    end else begin
      r.top  = stack_mirror[mirror_fill-1];
      r.peak = stack_mirror[top_peak_index()];
    end
    r.fill = 7'(mirror_fill);
    if (mirror_fill > deepest) begin
      deepest = mirror_fill;
    end
    return r;
  endfunction

  function automatic msk_op_e draw_op(input phase_e kind);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (kind)
      PH_FILL:  return (roll < 85) ? OP_PUSH : msk_op_e'(roll % 4);
      PH_DRAIN: return (roll < 45) ? OP_POP : (roll < 85) ? OP_POPMAX : msk_op_e'(roll % 4);
      PH_PEAKS: return (roll < 50) ? OP_PUSH : (roll < 90) ? OP_POPMAX : msk_op_e'(roll % 4);
      default:  return msk_op_e'(roll % 4);
    endcase
  endfunction

  // A narrow band of values makes equal maxima common.
  function automatic logic [31:0] draw_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      return 32'(int'($urandom_range(0, 8)) - 4);
    end else if (roll < 35) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("[%0t] result beat %0d: %s is %h, should be %h", $time, beats_checked, what,
               got, want);
    end
    mismatches++;
  endtask

  task automatic send_item(input msk_op_e op, input logic [31:0] value, input bit hand,
                           input stack_result_t hand_res);
    int unsigned   gap;
    stack_result_t r;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    r = apply_stack_op(op, value);
    owed_results.push_back(hand ? hand_res : r);
    items_sent++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (owed_results.size() == 0) begin
        report_mismatch("beat with no result owed", m_tdata[31:0], 32'h0);
      end else begin
        want = owed_results.pop_front();
        if (m_tdata[31:0] !== want.removed) report_mismatch("removed", m_tdata[31:0], want.removed);
        if (m_tdata[63:32] !== want.top) report_mismatch("top", m_tdata[63:32], want.top);
        if (m_tdata[95:64] !== want.peak) report_mismatch("max", m_tdata[95:64], want.peak);
        if (m_tdata[102:96] !== want.fill) begin
          report_mismatch("fill", 32'(m_tdata[102:96]), 32'(want.fill));
        end
        if (m_tdata[104:103] !== want.status) begin
          report_mismatch("status", 32'(m_tdata[104:103]), 32'(want.status));
        end
        if (m_tdata[111:105] !== 7'd0) report_mismatch("pad", 32'(m_tdata[111:105]), 32'h0);
      end
      beats_checked++;
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Stalled for %0d cycles with %0d results outstanding", idle_cycles,
                 owed_results.size());
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: stalls a random number of cycles before each result, with calm stretches.
  initial begin
    int unsigned gap;
    int unsigned stretch;
    bit          rx_calm;
    m_tready = 1'b0;
    rx_calm  = 1'b0;
    stretch  = 0;
    @(posedge rst_n);
    forever begin
      if (stretch == 0) begin
        stretch = $urandom_range(10, 60);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      gap = rx_calm ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    stack_result_t hand_res;
    phase_e        kind;
    int unsigned   span;
    int unsigned   n;
    clk            = 1'b0;
    rst_n          = 1'b0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    mirror_fill    = 0;
    items_sent     = 0;
    beats_checked  = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    full_refusals  = 0;
    empty_refusals = 0;
    peak_pops      = 0;
    deepest        = 0;
    tx_calm        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (n = 0; n < DIR_ROWS; n++) begin
      hand_res.removed = dir_rows[n].removed;
      hand_res.top     = dir_rows[n].top;
      hand_res.peak    = dir_rows[n].peak;
      hand_res.fill    = dir_rows[n].fill;
      hand_res.status  = dir_rows[n].status;
      send_item(dir_rows[n].op, dir_rows[n].value, dir_rows[n].hand, hand_res);
    end

    // Random phases lean toward filling, draining or pop-max, or mix the ops evenly, so both bounds are hit often.
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      kind    = phase_e'($urandom_range(0, 3));
      span    = $urandom_range(20, 120);
      tx_calm = ($urandom_range(0, 3) == 0);
      repeat (span) send_item(draw_op(kind), draw_value(), 1'b0, hand_res);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d results; deepest fill %0d of %0d.", items_sent,
             beats_checked, deepest, DEPTH);
    $display("Refused pushes on full: %0d, refused pops on empty: %0d, pop-max removals: %0d.",
             full_refusals, empty_refusals, peak_pops);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/msk_pkg.sv
design/msk_ctrl.sv
design/msk_datapath.sv
design/max_stack_engine.sv
verif/tb_max_stack_engine.sv
